FILE: sv/abac_pkg.sv
package abac_pkg;

	localparam int unsigned ALIGN_BYTES = 64;
	localparam logic [32:0] ALIGN_MASK = 33'(ALIGN_BYTES - 1);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_BEGIN = 2'd1;
	localparam logic [1:0] OP_BYTE  = 2'd2;
	localparam logic [1:0] OP_RESET = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_DISABLED  = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_BUSY      = 3'd4;
	localparam logic [2:0] ST_NOWRITE   = 3'd5;

	localparam logic [1:0] CFG_POOL_ENABLE = 2'd0;
	localparam logic [1:0] CFG_POOL_SIZE   = 2'd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] offset;
		logic [31:0] region_length;
		logic [31:0] checksum;
		logic [31:0] used_bytes;
		logic [31:0] byte_address;
		logic [7:0]  byte_data;
		logic        byte_valid;
		logic        done_res;
	} res_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/abac_region_check.sv
module abac_region_check
	import abac_pkg::*;
(
	input  logic [31:0] cursor,
	input  logic [31:0] length,
	input  logic [31:0] pool_size,
	input  logic        pool_enable,
	output logic [2:0]  status,
	output logic [31:0] start
);

	logic [32:0] off;
	logic [32:0] room;
	logic [32:0] size_ext;

	always_comb begin
		size_ext = {1'b0, pool_size};
		off      = ({1'b0, cursor} + ALIGN_MASK) & ~ALIGN_MASK;
		room     = size_ext - off;
		start    = off[31:0];
		priority if (length == 32'd0) begin
			status = ST_ZERO;
		end else if (!pool_enable) begin
			status = ST_DISABLED;
		end else if (off > size_ext || {1'b0, length} > room) begin
			status = ST_EXHAUSTED;
		end else begin
			status = ST_OK;
		end
	end

endmodule

FILE: sv/abac_engine.sv
module abac_engine
	import abac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        step,
	input  item_t       item,
	output res_t        res
);

	logic        enable_q;
	logic [31:0] size_q;
	logic [31:0] cursor_q, cursor_n;
	logic        open_q, open_n;
	logic [31:0] woff_q, woff_n;
	logic [31:0] wlen_q, wlen_n;
	logic [31:0] left_q, left_n;
	logic [31:0] crc_q, crc_n;
	logic [31:0] addr_q, addr_n;
	logic [31:0] crc_new;
	logic [2:0]  chk_status;
	logic [31:0] chk_start;

	abac_region_check u_check (
		.cursor      (cursor_q),
		.length      (item.length),
		.pool_size   (size_q),
		.pool_enable (enable_q),
		.status      (chk_status),
		.start       (chk_start)
	);

	always_comb begin
		crc_new  = crc_byte(crc_q, item.data_byte);
		cursor_n = cursor_q;
		open_n   = open_q;
		woff_n   = woff_q;
		wlen_n   = wlen_q;
		left_n   = left_q;
		crc_n    = crc_q;
		addr_n   = addr_q;
		res      = '0;
		res.status = ST_OK;
		if (item.operation == OP_BYTE) begin
			if (!open_q) begin
				res.status = ST_NOWRITE;
			end else begin
				res.byte_address  = addr_q;
				res.byte_data     = item.data_byte;
				res.byte_valid    = 1'b1;
				res.offset        = woff_q;
				res.region_length = wlen_q;
				crc_n  = crc_new;
				left_n = left_q - 32'd1;
				addr_n = addr_q + 32'd1;
				if (left_q == 32'd1) begin
					res.checksum = crc_new ^ CRC_INIT;
					res.done_res = 1'b1;
					cursor_n     = woff_q + wlen_q;
					open_n       = 1'b0;
					crc_n        = CRC_INIT;
				end
			end
		end else if (open_q) begin
			res.status = ST_BUSY;
		end else if (item.operation == OP_RESET) begin
			cursor_n = '0;
		end else begin
			res.status = chk_status;
			if (chk_status == ST_OK) begin
				res.offset        = chk_start;
				res.region_length = item.length;
				if (item.operation == OP_ALLOC) begin
					cursor_n     = chk_start + item.length;
					res.done_res = 1'b1;
				end else begin
					open_n = 1'b1;
					woff_n = chk_start;
					wlen_n = item.length;
					left_n = item.length;
					addr_n = chk_start;
					crc_n  = CRC_INIT;
				end
			end
		end
		res.used_bytes = cursor_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			size_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_ENABLE: enable_q <= cfg_data[0];
				CFG_POOL_SIZE:   size_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			open_q   <= 1'b0;
			woff_q   <= '0;
			wlen_q   <= '0;
			left_q   <= '0;
			crc_q    <= CRC_INIT;
			addr_q   <= '0;
		end else if (step) begin
			cursor_q <= cursor_n;
			open_q   <= open_n;
			woff_q   <= woff_n;
			wlen_q   <= wlen_n;
			left_q   <= left_n;
			crc_q    <= crc_n;
			addr_q   <= addr_n;
		end
	end

`ifndef SYNTHESIS
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> left_q != 32'd0)
		else $error("open write with no bytes left");

	a_closed_crc_init: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> crc_q == CRC_INIT)
		else $error("crc not reseeded while no write open");

	a_addr_track: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> addr_q == woff_q + (wlen_q - left_q))
		else $error("byte address out of step with bytes left");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(step && open_q && item.operation == OP_BYTE && left_q == 32'd1)
		|=> !open_q && cursor_q == $past(woff_q + wlen_q))
		else $error("last byte did not close the write");
`endif

endmodule

FILE: sv/aligned_bump_allocator_crc32.sv
// an item passes through the input register and engine to the output register
// one item per cycle if output not stalled; single engine pass and crc byte step
// the input register refills in the cycle its item moves to the output register
// reset: asynchronous, clears pool registers, cursor and open write, crc to all ones
module aligned_bump_allocator_crc32
	import abac_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,   // length, data_byte
	input  logic [1:0]   s_axis_tuser,   // operation
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [167:0] m_axis_tdata,   // offset, region_length, checksum, used_bytes,
	                                     // byte_address, byte_data
	output logic [4:0]   m_axis_tuser,   // status, byte_valid, done_res
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic  valid_s1;
	item_t item_s1;
	logic  adv;
	logic  out_valid_q;
	res_t  res_q;
	res_t  res_c;

	assign cfg_ready     = 1'b1;
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation <= s_axis_tuser;
			item_s1.length    <= s_axis_tdata[31:0];
			item_s1.data_byte <= s_axis_tdata[39:32];
		end
	end

	abac_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (adv),
		.item      (item_s1),
		.res       (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.byte_data, res_q.byte_address, res_q.used_bytes,
		res_q.checksum, res_q.region_length, res_q.offset};
	assign m_axis_tuser  = {res_q.done_res, res_q.byte_valid, res_q.status};

endmodule
